[rtl/core/cyl_pkg.sv]
package cyl_pkg;

   // register stages through one vector normalizer
   localparam int NORM_LAT = 70;
   localparam int UNIT_W   = 32;

   // three Q2.30 components, x in the lowest slot
   typedef logic [2:0][UNIT_W-1:0] unit_vec_type;

   typedef struct packed {
      logic valid;
      logic zero;
   } norm_stat_type;

   typedef enum logic [2:0] {
      CSR_AXIS_X   = 3'd0,
      CSR_AXIS_Y   = 3'd1,
      CSR_AXIS_Z   = 3'd2,
      CSR_ORIGIN_X = 3'd3,
      CSR_ORIGIN_Y = 3'd4,
      CSR_ORIGIN_Z = 3'd5,
      CSR_VELOCITY = 3'd6
   } csr_index_type;

endpackage

[rtl/core/cyl_norm.sv]
module cyl_norm #(
   parameter int IN_W = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  logic [2:0][IN_W-1:0]    in_vec,
   output cyl_pkg::unit_vec_type   out_unit,
   output cyl_pkg::norm_stat_type  out_stat
);

   localparam int PW        = $clog2(IN_W);
   localparam int SH_W      = PW + 1;
   localparam int SQ_STEPS  = 32;
   localparam int DIV_STEPS = 31;

   logic [cyl_pkg::NORM_LAT-1:0] vld_ff;

   // stage 1: sign and magnitude
   logic [2:0]             neg1_in, neg1_ff;
   logic [2:0][IN_W-1:0]   mag1_in, mag1_ff;
   // stage 2: largest magnitude
   logic [IN_W-1:0]        max2_in, max2_ff;
   logic [2:0]             neg2_ff;
   logic [2:0][IN_W-1:0]   mag2_ff;
   // stage 3: leading one
   logic [PW-1:0]          pos3_in, pos3_ff;
   logic                   zero3_ff;
   logic [2:0]             neg3_ff;
   logic [2:0][IN_W-1:0]   mag3_ff;
   // stage 4: scaled so the largest is in [2^30, 2^31)
   logic [2:0][30:0]       sc4_in, sc4_ff;
   logic [2:0]             neg4_ff;
   logic                   zero4_ff;
   // stage 5: squares
   logic [2:0][61:0]       sq5_in, sq5_ff;
   logic [2:0][30:0]       sc5_ff;
   logic [2:0]             neg5_ff;
   logic                   zero5_ff;
   // stage 6: sum of squares
   logic [63:0]            sum6_in, sum6_ff;
   logic [2:0][30:0]       sc6_ff;
   logic [2:0]             neg6_ff;
   logic                   zero6_ff;
   // square root, one result bit per stage
   logic [63:0]            sn_in [SQ_STEPS-1];
   logic [63:0]            sn_ff [SQ_STEPS-1];
   logic [63:0]            sr_in [SQ_STEPS];
   logic [63:0]            sr_ff [SQ_STEPS];
   logic [2:0][30:0]       sm_ff [SQ_STEPS];
   logic [2:0]             sg_ff [SQ_STEPS];
   logic                   sz_ff [SQ_STEPS];
   // restoring division, one quotient bit per stage
   logic [2:0][32:0]       dx_in [DIV_STEPS];
   logic [2:0][32:0]       dx_ff [DIV_STEPS];
   logic [2:0][30:0]       dq_in [DIV_STEPS];
   logic [2:0][30:0]       dq_ff [DIV_STEPS];
   logic [31:0]            ds_ff [DIV_STEPS];
   logic [2:0]             dg_ff [DIV_STEPS];
   logic                   dz_ff [DIV_STEPS];
   // output
   cyl_pkg::unit_vec_type  unit_in, unit_ff;
   logic                   zero_ff;

   logic [SH_W-1:0] pos_wide;
   logic            pos_ge;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = in_vec[i][IN_W-1];
         mag1_in[i] = in_vec[i][IN_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
      end
      max2_in = mag1_ff[0];
      if (mag1_ff[1] > max2_in) max2_in = mag1_ff[1];
      if (mag1_ff[2] > max2_in) max2_in = mag1_ff[2];
      pos3_in = '0;
      for (int b = 0; b < IN_W; b++) begin
         if (max2_ff[b]) pos3_in = PW'(b);
      end
   end

   assign pos_wide = {1'b0, pos3_ff};
   assign pos_ge   = pos_wide >= SH_W'(30);

   always_comb begin
      logic [IN_W+30:0] wide;
      for (int i = 0; i < 3; i++) begin
         wide = {31'd0, mag3_ff[i]};
         if (pos_ge) begin
            wide = wide >> (pos_wide - SH_W'(30));
         end else begin
            wide = wide << (SH_W'(30) - pos_wide);
         end
         sc4_in[i] = wide[30:0];
         sq5_in[i] = 62'(sc4_ff[i]) * 62'(sc4_ff[i]);
      end
      sum6_in = 64'(sq5_ff[0]) + 64'(sq5_ff[1]) + 64'(sq5_ff[2]);
   end

   // integer square root of the sum
   always_comb begin
      logic [63:0] n, r, b, trial;
      for (int k = 0; k < SQ_STEPS; k++) begin
         n = (k == 0) ? sum6_ff : sn_ff[(k == 0) ? 0 : k-1];
         r = (k == 0) ? 64'd0 : sr_ff[(k == 0) ? 0 : k-1];
         b = 64'd1 << (62 - 2*k);
         trial = r + b;
         if (n >= trial) begin
            sr_in[k] = (r >> 1) + b;
            if (k < SQ_STEPS-1) sn_in[k] = n - trial;
         end else begin
            sr_in[k] = r >> 1;
            if (k < SQ_STEPS-1) sn_in[k] = n;
         end
      end
   end

   // magnitude * 2^30 / root
   always_comb begin
      logic        ge;
      logic [32:0] rem;
      logic [30:0] q;
      for (int i = 0; i < 3; i++) begin
         dx_in[0][i] = {2'b00, sm_ff[SQ_STEPS-1][i]};
         dq_in[0][i] = '0;
      end
      unit_in = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
         for (int i = 0; i < 3; i++) begin
            ge  = dx_ff[k][i] >= {1'b0, ds_ff[k]};
            rem = ge ? (dx_ff[k][i] - {1'b0, ds_ff[k]}) : dx_ff[k][i];
            q   = {dq_ff[k][i][29:0], ge};
            if (k < DIV_STEPS-1) begin
               dx_in[(k < DIV_STEPS-1) ? k+1 : 0][i] = {rem[31:0], 1'b0};
               dq_in[(k < DIV_STEPS-1) ? k+1 : 0][i] = q;
            end else begin
               unit_in[i] = dg_ff[k][i] ? (~{1'b0, q} + 1'b1) : {1'b0, q};
               if (dz_ff[k]) unit_in[i] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[cyl_pkg::NORM_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         neg1_ff  <= neg1_in;
         mag1_ff  <= mag1_in;
         max2_ff  <= max2_in;
         neg2_ff  <= neg1_ff;
         mag2_ff  <= mag1_ff;
         pos3_ff  <= pos3_in;
         zero3_ff <= max2_ff == '0;
         neg3_ff  <= neg2_ff;
         mag3_ff  <= mag2_ff;
         sc4_ff   <= sc4_in;
         neg4_ff  <= neg3_ff;
         zero4_ff <= zero3_ff;
         sq5_ff   <= sq5_in;
         sc5_ff   <= sc4_ff;
         neg5_ff  <= neg4_ff;
         zero5_ff <= zero4_ff;
         sum6_ff  <= sum6_in;
         sc6_ff   <= sc5_ff;
         neg6_ff  <= neg5_ff;
         zero6_ff <= zero5_ff;
         for (int k = 0; k < SQ_STEPS; k++) begin
            sr_ff[k] <= sr_in[k];
            if (k < SQ_STEPS-1) sn_ff[(k < SQ_STEPS-1) ? k : 0] <= sn_in[(k < SQ_STEPS-1) ? k : 0];
            if (k == 0) begin
               sm_ff[k] <= sc6_ff;
               sg_ff[k] <= neg6_ff;
               sz_ff[k] <= zero6_ff;
            end else begin
               sm_ff[k] <= sm_ff[(k == 0) ? 0 : k-1];
               sg_ff[k] <= sg_ff[(k == 0) ? 0 : k-1];
               sz_ff[k] <= sz_ff[(k == 0) ? 0 : k-1];
            end
         end
         for (int k = 0; k < DIV_STEPS; k++) begin
            dx_ff[k] <= dx_in[k];
            dq_ff[k] <= dq_in[k];
            if (k == 0) begin
               ds_ff[k] <= sr_ff[SQ_STEPS-1][31:0];
               dg_ff[k] <= sg_ff[SQ_STEPS-1];
               dz_ff[k] <= sz_ff[SQ_STEPS-1];
            end else begin
               ds_ff[k] <= ds_ff[(k == 0) ? 0 : k-1];
               dg_ff[k] <= dg_ff[(k == 0) ? 0 : k-1];
               dz_ff[k] <= dz_ff[(k == 0) ? 0 : k-1];
            end
         end
         unit_ff <= unit_in;
         zero_ff <= dz_ff[DIV_STEPS-1];
      end
   end

   assign out_unit       = unit_ff;
   assign out_stat.valid = vld_ff[cyl_pkg::NORM_LAT-1];
   assign out_stat.zero  = zero_ff;

endmodule

[rtl/core/cylindrical_inlet_velocity.sv]
// swirl inlet velocity at a face centre, one word in and one word out
// pipeline from req accept to rsp_tvalid: 7 offset/projection stages,
//   70 in the radial normalizer, 6 for cross product, weighting and rounding
// throughput: one word per cycle; the whole pipe freezes only while rsp is stalled
// reset: synchronous, registers take their reset values and req_tready stays low
//   while the axis normalizer fills; any csr write holds it low again until
//   the hold counter has run down
module cylindrical_inlet_velocity (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // face_x, face_y, face_z
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // vel_x, vel_y, vel_z
   output logic [0:0]  rsp_tuser,   // degenerate
   // configuration writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   localparam logic signed [66:0] SAT_HI = 67'sd2147483647;
   localparam logic signed [66:0] SAT_LO = -67'sd2147483648;
   localparam int CNT_W = $clog2(cyl_pkg::NORM_LAT + 1);

   // round to nearest, halves away from zero, then shift right by k
   function automatic logic signed [66:0] rshift_round(input logic signed [66:0] v,
                                                       input int k);
      logic [66:0] u;
      u = v[66] ? 67'(-v) : 67'(v);
      u = (u + (67'(1) << (k - 1))) >> k;
      return v[66] ? -$signed(u) : $signed(u);
   endfunction

   // configuration registers
   logic [2:0][31:0] axis_ff;
   logic [2:0][31:0] origin_ff;
   logic [47:0]      vel_ff;
   logic [CNT_W-1:0] hcnt_ff;

   // unit axis, recomputed continuously from the axis registers
   cyl_pkg::unit_vec_type  h_unit;
   cyl_pkg::norm_stat_type h_stat;

   logic adv;       // pipe moves this cycle
   logic h_ok;      // unit axis settled

   // offset and projection stages
   logic              va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff;
   logic signed [32:0] ra_in [3];
   logic signed [32:0] ra_ff [3];
   logic signed [32:0] rb_ff [3];
   logic signed [32:0] rc_ff [3];
   logic signed [32:0] rd_ff [3];
   logic signed [32:0] re_ff [3];
   logic signed [32:0] rf_ff [3];
   logic signed [64:0] hr_in [3];
   logic signed [64:0] hr_ff [3];
   logic signed [66:0] dot_in, dot_ff;
   logic signed [34:0] t_in, t_ff;
   logic signed [66:0] th_in [3];
   logic signed [66:0] th_ff [3];
   logic signed [37:0] thr_in [3];
   logic signed [37:0] thr_ff [3];
   logic signed [35:0] d_in [3];
   logic signed [35:0] d_ff [3];
   logic [2:0][35:0]   d_vec;

   // radial unit vector
   cyl_pkg::unit_vec_type  e_unit;
   cyl_pkg::norm_stat_type e_stat;

   // cross product and weighting stages
   logic               vx1_ff, vx2_ff, vx3_ff, vy1_ff, vy2_ff;
   logic               dg1_ff, dg2_ff, dg3_ff, dgy1_ff, dgy2_ff;
   cyl_pkg::unit_vec_type e1_ff, e2_ff, e3_ff;
   logic signed [63:0] xp_in [6];
   logic signed [63:0] xp_ff [6];
   logic signed [64:0] xd_in [3];
   logic signed [64:0] xd_ff [3];
   logic signed [32:0] c_in [3];
   logic signed [32:0] c_ff [3];
   logic signed [48:0] tc_in [3];
   logic signed [48:0] tc_ff [3];
   logic signed [47:0] ah_in [3];
   logic signed [47:0] ah_ff [3];
   logic signed [47:0] er_in [3];
   logic signed [47:0] er_ff [3];
   logic signed [50:0] acc_in [3];
   logic signed [50:0] acc_ff [3];
   logic signed [15:0] tang, rad, axl;

   // output register
   logic        rsp_tvalid_ff;
   logic [95:0] rsp_tdata_in, rsp_tdata_ff;
   logic        rsp_tuser_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign h_ok       = (hcnt_ff == '0) && h_stat.valid;
   assign req_tready = adv && h_ok;

   // configuration port, unknown indexes fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff   <= {32'h0001_0000, 32'h0000_0000, 32'h0000_0000};
         origin_ff <= '0;
         vel_ff    <= '0;
         hcnt_ff   <= '0;
      end else begin
         if (csr_we) begin
            hcnt_ff <= CNT_W'(cyl_pkg::NORM_LAT);
            unique case (cyl_pkg::csr_index_type'(csr_index))
               cyl_pkg::CSR_AXIS_X:   axis_ff[0]   <= csr_wdata[31:0];
               cyl_pkg::CSR_AXIS_Y:   axis_ff[1]   <= csr_wdata[31:0];
               cyl_pkg::CSR_AXIS_Z:   axis_ff[2]   <= csr_wdata[31:0];
               cyl_pkg::CSR_ORIGIN_X: origin_ff[0] <= csr_wdata[31:0];
               cyl_pkg::CSR_ORIGIN_Y: origin_ff[1] <= csr_wdata[31:0];
               cyl_pkg::CSR_ORIGIN_Z: origin_ff[2] <= csr_wdata[31:0];
               cyl_pkg::CSR_VELOCITY: vel_ff       <= csr_wdata;
               default: ;
            endcase
         end else if (hcnt_ff != '0) begin
            hcnt_ff <= hcnt_ff - 1'b1;
         end
      end
   end

   // axis normalizer runs free; the user keeps h constant for items, not enforced
   cyl_norm #(.IN_W(32)) u_axis_norm (
      .clock    (clock),
      .reset    (reset),
      .enable   (1'b1),
      .in_valid (1'b1),
      .in_vec   (axis_ff),
      .out_unit (h_unit),
      .out_stat (h_stat)
   );

   assign tang = $signed(vel_ff[47:32]);
   assign rad  = $signed(vel_ff[31:16]);
   assign axl  = $signed(vel_ff[15:0]);

   // offset, dot product, axial removal
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ra_in[i]  = 33'($signed(req_tdata[32*i +: 32])) - 33'($signed(origin_ff[i]));
         hr_in[i]  = $signed(h_unit[i]) * ra_ff[i];
         th_in[i]  = t_ff * $signed(h_unit[i]);
         thr_in[i] = 38'(rshift_round(th_ff[i], 30));
         d_in[i]   = 36'(39'(rf_ff[i]) - 39'(thr_ff[i]));
         d_vec[i]  = d_ff[i];
      end
      dot_in = 67'(hr_ff[0]) + 67'(hr_ff[1]) + 67'(hr_ff[2]);
      t_in   = 35'(rshift_round(dot_ff, 30));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= req_tvalid && h_ok;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
         vg_ff <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ra_ff  <= ra_in;
         rb_ff  <= ra_ff;
         rc_ff  <= rb_ff;
         rd_ff  <= rc_ff;
         re_ff  <= rd_ff;
         rf_ff  <= re_ff;
         hr_ff  <= hr_in;
         dot_ff <= dot_in;
         t_ff   <= t_in;
         th_ff  <= th_in;
         thr_ff <= thr_in;
         d_ff   <= d_in;
      end
   end

   // radial direction, zero flag marks a point on the axis
   cyl_norm #(.IN_W(36)) u_radial_norm (
      .clock    (clock),
      .reset    (reset),
      .enable   (adv),
      .in_valid (vg_ff),
      .in_vec   (d_vec),
      .out_unit (e_unit),
      .out_stat (e_stat)
   );

   // h x e, then tangential, axial and radial weights
   always_comb begin
      xp_in[0] = $signed(h_unit[1]) * $signed(e_unit[2]);
      xp_in[1] = $signed(h_unit[2]) * $signed(e_unit[1]);
      xp_in[2] = $signed(h_unit[2]) * $signed(e_unit[0]);
      xp_in[3] = $signed(h_unit[0]) * $signed(e_unit[2]);
      xp_in[4] = $signed(h_unit[0]) * $signed(e_unit[1]);
      xp_in[5] = $signed(h_unit[1]) * $signed(e_unit[0]);
      for (int i = 0; i < 3; i++) begin
         xd_in[i]  = 65'(xp_ff[2*i]) - 65'(xp_ff[2*i+1]);
         c_in[i]   = 33'(rshift_round(67'(xd_ff[i]), 30));
         tc_in[i]  = tang * c_ff[i];
         ah_in[i]  = axl * $signed(h_unit[i]);
         er_in[i]  = rad * $signed(e3_ff[i]);
         acc_in[i] = 51'(tc_ff[i]) + 51'(ah_ff[i]) + 51'(er_ff[i]);
      end
   end

   // final rounding to Q16.16 with clamp, zero for degenerate words
   always_comb begin
      logic signed [66:0] rv;
      logic [31:0]        vo;
      rsp_tdata_in = '0;
      for (int i = 0; i < 3; i++) begin
         rv = rshift_round(67'(acc_ff[i]), 22);
         priority if (rv > SAT_HI) vo = 32'h7FFF_FFFF;
         else if (rv < SAT_LO)     vo = 32'h8000_0000;
         else                      vo = rv[31:0];
         if (dgy2_ff) vo = '0;
         rsp_tdata_in[32*i +: 32] = vo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vx1_ff        <= 1'b0;
         vx2_ff        <= 1'b0;
         vx3_ff        <= 1'b0;
         vy1_ff        <= 1'b0;
         vy2_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         vx1_ff        <= e_stat.valid;
         vx2_ff        <= vx1_ff;
         vx3_ff        <= vx2_ff;
         vy1_ff        <= vx3_ff;
         vy2_ff        <= vy1_ff;
         rsp_tvalid_ff <= vy2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xp_ff        <= xp_in;
         e1_ff        <= e_unit;
         dg1_ff       <= h_stat.zero || e_stat.zero;
         xd_ff        <= xd_in;
         e2_ff        <= e1_ff;
         dg2_ff       <= dg1_ff;
         c_ff         <= c_in;
         e3_ff        <= e2_ff;
         dg3_ff       <= dg2_ff;
         tc_ff        <= tc_in;
         ah_ff        <= ah_in;
         er_ff        <= er_in;
         dgy1_ff      <= dg3_ff;
         acc_ff       <= acc_in;
         dgy2_ff      <= dgy1_ff;
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= dgy2_ff;
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_tdata_ff;
   assign rsp_tuser[0] = rsp_tuser_ff;

endmodule

[dv/tb_cylindrical_inlet_velocity.sv]
`timescale 1ns / 1ps

module tb_cylindrical_inlet_velocity;

   // one expected result word
   typedef struct {
      logic [31:0] vel_x;
      logic [31:0] vel_y;
      logic [31:0] vel_z;
      logic        degenerate;
   } velocity_word_type;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PIPE_SETTLE    = 100;   // a bit more than the pipeline latency
   localparam int HOLD_CYCLES    = 400;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata   = '0;   // face_x, face_y, face_z
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [95:0] rsp_tdata;          // vel_x, vel_y, vel_z
   logic [0:0]  rsp_tuser;          // degenerate
   logic        csr_we      = 1'b0;
   logic [2:0]  csr_index   = '0;
   logic [47:0] csr_wdata   = '0;

   // shadow copy of the block's registers
   logic [31:0] axis_reg [3];
   logic [31:0] origin_reg [3];
   logic [47:0] speed_reg;

   velocity_word_type velocity_queue [$];
   int  mismatch_count = 0;
   int  points_sent    = 0;
   int  words_checked  = 0;
   int  degenerate_seen = 0;
   int  config_sets    = 0;
   int  idle_count     = 0;
   bit  sender_calm    = 1'b0;
   bit  receiver_calm  = 1'b0;
   bit  hold_request   = 1'b0;
   int  hold_left      = 0;

   cylindrical_inlet_velocity u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // fixed point velocity prediction
   // ---------------------------------------------------------------

   // round to nearest, halves away from zero, dropping k bits
   function automatic longint round_away(input longint v, input int k);
      longint unsigned mag;
      mag = (v < 0) ? (64'd0 - longint'(v)) : longint'(v);
      mag = (mag + (64'd1 << (k - 1))) >> k;
      return (v < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned root;
      longint unsigned bit_w;
      root  = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > n) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (n >= root + bit_w) begin
            n    = n - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root;
   endfunction

   // Q2.30 unit vector; returns 0 for the zero vector
   function automatic bit unit_q30(input longint vx, input longint vy, input longint vz,
                                   output longint ux, output longint uy, output longint uz);
      longint          comp [3];
      longint          unit [3];
      longint unsigned mag [3];
      bit              neg [3];
      longint unsigned peak;
      longint unsigned sum_sq;
      longint unsigned len;
      comp[0] = vx; comp[1] = vy; comp[2] = vz;
      peak = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i]  = comp[i] < 0;
         mag[i]  = neg[i] ? (64'd0 - longint'(comp[i])) : longint'(comp[i]);
         unit[i] = 0;
         if (mag[i] > peak) peak = mag[i];
      end
      ux = 0; uy = 0; uz = 0;
      if (peak == 0) return 1'b0;
      // bring the largest magnitude into [2^30, 2^31)
      while (peak >= (64'd1 << 31)) begin
         peak = peak >> 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      while (peak < (64'd1 << 30)) begin
         peak = peak << 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      sum_sq = 0;
      for (int i = 0; i < 3; i++) sum_sq = sum_sq + mag[i] * mag[i];
      len = int_sqrt(sum_sq);
      for (int i = 0; i < 3; i++) begin
         unit[i] = longint'((mag[i] << 30) / len);
         if (neg[i]) unit[i] = -unit[i];
      end
      ux = unit[0]; uy = unit[1]; uz = unit[2];
      return 1'b1;
   endfunction

   function automatic logic [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic velocity_word_type inlet_velocity(input logic [95:0] point);
      velocity_word_type res;
      longint axis [3];
      longint rel [3];
      longint h [3];
      longint d [3];
      longint e [3];
      longint c [3];
      longint dot;
      longint along;
      longint tang;
      longint rad;
      longint axl;
      longint acc;
      res.vel_x = '0; res.vel_y = '0; res.vel_z = '0; res.degenerate = 1'b1;
      for (int i = 0; i < 3; i++) begin
         axis[i] = longint'(signed'(axis_reg[i]));
         rel[i]  = longint'(signed'(point[32*i +: 32])) - longint'(signed'(origin_reg[i]));
      end
      if (!unit_q30(axis[0], axis[1], axis[2], h[0], h[1], h[2])) return res;
      // strip the axial part of the offset
      dot = 0;
      for (int i = 0; i < 3; i++) dot = dot + h[i] * rel[i];
      along = round_away(dot, 30);
      for (int i = 0; i < 3; i++) d[i] = rel[i] - round_away(along * h[i], 30);
      if (!unit_q30(d[0], d[1], d[2], e[0], e[1], e[2])) return res;
      // tangential direction h x e
      c[0] = round_away(h[1] * e[2] - h[2] * e[1], 30);
      c[1] = round_away(h[2] * e[0] - h[0] * e[2], 30);
      c[2] = round_away(h[0] * e[1] - h[1] * e[0], 30);
      tang = longint'(signed'(speed_reg[47:32]));
      rad  = longint'(signed'(speed_reg[31:16]));
      axl  = longint'(signed'(speed_reg[15:0]));
      acc = tang * c[0] + axl * h[0] + rad * e[0];
      res.vel_x = clamp32(round_away(acc, 22));
      acc = tang * c[1] + axl * h[1] + rad * e[1];
      res.vel_y = clamp32(round_away(acc, 22));
      acc = tang * c[2] + axl * h[2] + rad * e[2];
      res.vel_z = clamp32(round_away(acc, 22));
      res.degenerate = 1'b0;
      return res;
   endfunction

   // ---------------------------------------------------------------
   // shared stimulus tasks
   // ---------------------------------------------------------------

   // offer one face centre, predict on accept; valid stays high afterward
   task automatic send_point(input logic [31:0] fx, input logic [31:0] fy,
                             input logic [31:0] fz);
      int gap;
      if (!sender_calm && $urandom_range(99) < 5) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {fz, fy, fx};
      do @(posedge clock); while (!req_tready);
      velocity_queue.push_back(inlet_velocity({fz, fy, fx}));
      points_sent++;
   endtask

   // sender pauses until every expected word is back and the pipe is empty
   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (velocity_queue.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   // write one register; the caller lowers csr_we after the last write
   task automatic write_csr(input cyl_pkg::csr_index_type idx, input logic [47:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      unique case (idx)
         cyl_pkg::CSR_AXIS_X:   axis_reg[0]   = value[31:0];
         cyl_pkg::CSR_AXIS_Y:   axis_reg[1]   = value[31:0];
         cyl_pkg::CSR_AXIS_Z:   axis_reg[2]   = value[31:0];
         cyl_pkg::CSR_ORIGIN_X: origin_reg[0] = value[31:0];
         cyl_pkg::CSR_ORIGIN_Y: origin_reg[1] = value[31:0];
         cyl_pkg::CSR_ORIGIN_Z: origin_reg[2] = value[31:0];
         cyl_pkg::CSR_VELOCITY: speed_reg     = value;
         default: ;
      endcase
   endtask

   task automatic load_config(input logic [31:0] ax, input logic [31:0] ay,
                              input logic [31:0] az, input logic [31:0] ox,
                              input logic [31:0] oy, input logic [31:0] oz,
                              input logic [47:0] speeds);
      drain_pipe();
      write_csr(cyl_pkg::CSR_AXIS_X, {16'h0, ax});
      write_csr(cyl_pkg::CSR_AXIS_Y, {16'h0, ay});
      write_csr(cyl_pkg::CSR_AXIS_Z, {16'h0, az});
      write_csr(cyl_pkg::CSR_ORIGIN_X, {16'h0, ox});
      write_csr(cyl_pkg::CSR_ORIGIN_Y, {16'h0, oy});
      write_csr(cyl_pkg::CSR_ORIGIN_Z, {16'h0, oz});
      write_csr(cyl_pkg::CSR_VELOCITY, speeds);
      csr_we <= 1'b0;
      config_sets++;
   endtask

   // a coordinate of any scale, so the normalizer shifts both ways
   function automatic logic [31:0] scaled_value();
      logic [31:0] v;
      v = $urandom >> $urandom_range(0, 31);
      return $urandom_range(1) ? -v : v;
   endfunction

   // mostly moderate points, some on the axis line, some fully random
   task automatic send_random_point();
      int          pick;
      int          sh;
      logic [31:0] p [3];
      pick = $urandom_range(99);
      sh   = $urandom_range(0, 20);
      for (int i = 0; i < 3; i++) begin
         if (pick < 65)      p[i] = origin_reg[i] + scaled_value();
         else if (pick < 80) p[i] = origin_reg[i] + (signed'(axis_reg[i]) >>> sh);
         else if (pick < 85) p[i] = origin_reg[i];
         else                p[i] = $urandom;
      end
      send_point(p[0], p[1], p[2]);
   endtask

   function automatic logic [31:0] random_axis_part();
      unique case ($urandom_range(5))
         0:       return 32'd0;
         1:       return 32'h8000_0000;
         2:       return 32'h7fff_ffff;
         default: return scaled_value();
      endcase
   endfunction

   // ---------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      $display("%0t mismatch on %s: expected %h actual %h", $time, field, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      velocity_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (velocity_queue.size() == 0) begin
            $display("%0t unexpected result word: expected none actual %h / %b",
                     $time, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = velocity_queue.pop_front();
            words_checked++;
            if (want.degenerate) degenerate_seen++;
            if (rsp_tdata[31:0] !== want.vel_x) report_field("vel_x", want.vel_x, rsp_tdata[31:0]);
            if (rsp_tdata[63:32] !== want.vel_y)
               report_field("vel_y", want.vel_y, rsp_tdata[63:32]);
            if (rsp_tdata[95:64] !== want.vel_z)
               report_field("vel_z", want.vel_z, rsp_tdata[95:64]);
            if (rsp_tuser[0] !== want.degenerate)
               report_field("degenerate", {31'd0, want.degenerate}, {31'd0, rsp_tuser[0]});
         end
      end
   end

   // receiver: random stalls, calm stretches, and one long hold on request
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= receiver_calm || ($urandom_range(99) >= 15);
      end
   end

   // watchdog on cycles where neither side moves a word
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no word moved for %0d cycles", $time, idle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // reset values: unit z axis at the origin, all speeds zero
   task automatic test_reset_defaults();
      send_point(32'h0001_0000, 32'h0, 32'h0);
      send_point(32'h0, 32'h0, 32'h0005_0000);   // on the axis
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678);
   endtask

   task automatic test_directed();
      // positive tangential, half radial, negative axial
      load_config(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0,
                  {16'h0100, 16'h0080, 16'hff00});
      send_point(32'h0001_0000, 32'h0, 32'h0);
      send_point(32'h0, 32'h0001_0000, 32'h0003_0000);
      send_point(32'hffff_ffff, 32'hffff_ffff, 32'h0);
      send_point(32'h0000_0001, 32'h0, 32'h8000_0000);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);
      send_point(32'h0, 32'h0, 32'h7fff_ffff);    // on the axis
      // zero axis: every point degenerate
      load_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 48'h0100_0100_0100);
      send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0);
      // extreme axis, origin and the largest speeds
      load_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 48'h7fff_7fff_7fff);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);   // on the axis
      load_config(32'h7fff_ffff, 32'h0000_0001, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 48'h8000_8000_8000);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_point(32'h0, 32'h0, 32'h0);
      // writes to the unused index must change nothing
      drain_pipe();
      write_csr(cyl_pkg::csr_index_type'(3'd7), 48'hffff_ffff_ffff);
      csr_we <= 1'b0;
      send_point(32'h0, 32'h7fff_ffff, 32'h0);
      send_point(32'h1234_5678, 32'h9abc_def0, 32'h0fed_cba9);
   endtask

   task automatic test_random_configs();
      for (int phase = 0; phase < 8; phase++) begin
         load_config(random_axis_part(), random_axis_part(), random_axis_part(),
                     $urandom, $urandom, (phase == 0) ? 32'h0 : scaled_value(),
                     48'({$urandom, $urandom}));
         // one phase with no idling at all on either side
         sender_calm   = (phase == 3);
         receiver_calm = (phase == 3);
         repeat (185) send_random_point();
      end
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;
   endtask

   // receiver holds off for a long stretch while the sender keeps offering
   task automatic test_backpressure();
      load_config(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0,
                  48'h0200_ff80_0040);
      sender_calm  = 1'b1;
      hold_request = 1'b1;
      repeat (200) send_random_point();
      sender_calm  = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < 3; i++) begin
         axis_reg[i]   = '0;
         origin_reg[i] = '0;
      end
      axis_reg[2] = 32'h0001_0000;
      speed_reg   = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed();
      test_random_configs();
      test_backpressure();
      drain_pipe();

      $display("sent %0d face centres over %0d register settings, checked %0d words",
               points_sent, config_sets, words_checked);
      $display("%0d degenerate words, one long output hold with input backpressure",
               degenerate_seen);
      if (mismatch_count == 0 && velocity_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d words still expected",
                  mismatch_count, velocity_queue.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
